// ===== src/spls_pkg.sv =====
// spls_pkg: command codes, register offsets and bit positions of the serial port
`default_nettype none

package spls_pkg;

  // bus / link command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // register byte offsets
  localparam logic [3:0] OFS_DATA    = 4'h0;
  localparam logic [3:0] OFS_STATUS  = 4'h4;
  localparam logic [3:0] OFS_MODE    = 4'h8;
  localparam logic [3:0] OFS_CONTROL = 4'hA;
  localparam logic [3:0] OFS_BAUD    = 4'hE;

  localparam logic [15:0] BAUD_RESET = 16'h00DC;
  localparam logic [31:0] READ_ONES  = 32'hFFFF_FFFF;

  // control register bits
  localparam int CTL_TXEN    = 0;
  localparam int CTL_DTR     = 1;
  localparam int CTL_RXEN    = 2;
  localparam int CTL_ACK     = 4;
  localparam int CTL_RTS     = 5;
  localparam int CTL_RESET   = 6;
  localparam int CTL_RXIM_LO = 8;
  localparam int CTL_RXIM_HI = 9;
  localparam int CTL_TXIE    = 10;
  localparam int CTL_RXIE    = 11;
  localparam int CTL_DSRIE   = 12;

  // status word bits
  localparam int STS_TXRDY   = 0;
  localparam int STS_RXNE    = 1;
  localparam int STS_TXIDLE  = 2;
  localparam int STS_OVERRUN = 4;
  localparam int STS_DSR     = 7;
  localparam int STS_CTS     = 8;
  localparam int STS_INTR    = 9;

  // received sync byte bits
  localparam int SYN_DATA = 0;
  localparam int SYN_DTR  = 1;
  localparam int SYN_RTS  = 2;

  // peer fifo count register width (sync byte count field is five bits)
  localparam int PEER_W   = 6;
  localparam int MAX_POP  = 7;

endpackage

`default_nettype wire

// ===== src/serial_port_with_link_sync.sv =====
// serial_port_with_link_sync: bus register port with receive fifo and synchronized link side
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------------
//  in      | in_valid, in_stall | cmd, offset, pop_len, wdata, link_up, rx_valid,
//          |                    | rx_sync, rx_byte
//  out     | out_valid,out_stall| rdata, tx_send, tx_sync, tx_byte, irq
//
//  one item per clock cycle sustained while the output is not stalled; each item gives exactly one result item
//  an item passes the input register, then the single-pass update into the result register
//  the receive fifo is a shift line of FIFO_DEPTH bytes; a data read shifts it by up to seven
//  synchronous reset returns all control and link state to its reset values; fifo bytes are not cleared
//  a stalled result holds the input register, which then stalls the input side
`default_nettype none

module serial_port_with_link_sync
  import spls_pkg::*;
#(
  parameter int FIFO_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  offset,
  input  wire logic [2:0]  pop_len,
  input  wire logic [31:0] wdata,
  input  wire logic        link_up,
  input  wire logic        rx_valid,
  input  wire logic [7:0]  rx_sync,
  input  wire logic [7:0]  rx_byte,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      rdata,
  output logic             tx_send,
  output logic [7:0]       tx_sync,
  output logic [7:0]       tx_byte,
  output logic             irq
);

  // count holds 0..FIFO_DEPTH, index addresses one entry
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int IW = $clog2(FIFO_DEPTH);
  localparam logic [CW-1:0]     DEPTH_C = CW'(FIFO_DEPTH);
  localparam logic [PEER_W-1:0] DEPTH_P = PEER_W'(FIFO_DEPTH);

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [3:0]  s1_offset;
  logic [2:0]  s1_pop_len;
  logic [31:0] s1_wdata;
  logic        s1_link_up;
  logic        s1_rx_valid;
  logic [7:0]  s1_rx_sync;
  logic [7:0]  s1_rx_byte;

  logic        s1_advance;
  logic        in_take;

  // the stage moves on when the result register is free or being emptied
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd       <= cmd;
      s1_offset    <= offset;
      s1_pop_len   <= pop_len;
      s1_wdata     <= wdata;
      s1_link_up   <= link_up;
      s1_rx_valid  <= rx_valid;
      s1_rx_sync   <= rx_sync;
      s1_rx_byte   <= rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // port state
  // ---------------------------------------------------------------------------
  logic [15:0]       control_reg, control_reg_next;
  logic [15:0]       mode_reg, mode_reg_next;
  logic [15:0]       baud_reg, baud_reg_next;
  logic [CW-1:0]     rx_count, rx_count_next;
  logic [7:0]        tx_hold, tx_hold_next;
  logic              tx_full, tx_full_next;
  logic              txen_latched, txen_latched_next;
  logic              overrun_flag, overrun_flag_next;
  logic              intr_flag, intr_flag_next;
  logic              irq_line, irq_line_next;
  logic              dsr_level, dsr_level_next;
  logic              cts_level, cts_level_next;
  logic              sent_dtr, sent_dtr_next;
  logic              sent_rts, sent_rts_next;
  logic [CW-1:0]     sent_count, sent_count_next;
  logic [PEER_W-1:0] peer_count, peer_count_next;
  logic              initial_sync_due, initial_sync_due_next;

  // receive fifo: entry 0 is the oldest byte
  logic [7:0] rx_store [FIFO_DEPTH];
  logic [7:0] shifted  [FIFO_DEPTH];
  logic [7:0] cand     [FIFO_DEPTH][MAX_POP+1];

  logic          do_pop;
  logic          do_push;
  logic [2:0]    pop_cnt;
  logic [IW-1:0] wr_idx;

  // result values
  logic [31:0] rdata_next;
  logic        tx_send_next;
  logic [7:0]  tx_sync_next;
  logic [7:0]  tx_byte_next;

  // helpers
  logic [31:0]       status_word;
  logic [31:0]       fifo_word;
  logic [3:0]        rx_thr;
  logic              tx_go;
  logic              reply;
  logic [5:0]        count6;

  // each entry picks the entry pop_cnt places further up
  for (genvar gi = 0; gi < FIFO_DEPTH; gi++) begin : g_shift
    for (genvar gk = 0; gk <= MAX_POP; gk++) begin : g_tap
      if (gi + gk < FIFO_DEPTH) begin : g_in
        assign cand[gi][gk] = rx_store[gi + gk];
      end else begin : g_out
        assign cand[gi][gk] = rx_store[gi];
      end
    end
    assign shifted[gi] = cand[gi][pop_cnt];
  end

  // pop count is min(pop_len, fill)
  assign pop_cnt = (CW'(s1_pop_len) < rx_count) ? s1_pop_len : 3'(rx_count);
  assign wr_idx  = rx_count[IW-1:0];

  // up to four oldest bytes, little-endian, bytes past the fill read as zero
  always_comb begin
    fifo_word = '0;
    for (int i = 0; i < 4; i++) begin
      if (CW'(i) < rx_count) begin
        fifo_word[8*i +: 8] = rx_store[i];
      end
    end
  end

  always_comb begin
    status_word = '0;
    status_word[STS_TXRDY]   = !tx_full && cts_level;
    status_word[STS_RXNE]    = (rx_count != '0);
    status_word[STS_TXIDLE]  = !tx_full;
    status_word[STS_OVERRUN] = overrun_flag;
    status_word[STS_DSR]     = dsr_level;
    status_word[STS_CTS]     = cts_level;
    status_word[STS_INTR]    = intr_flag;
  end

  // rx interrupt threshold 1, 2, 4 or 8
  assign rx_thr = 4'd1 << control_reg[CTL_RXIM_HI:CTL_RXIM_LO];

  // ---------------------------------------------------------------------------
  // single-pass update for one item
  // ---------------------------------------------------------------------------
  always_comb begin
    control_reg_next      = control_reg;
    mode_reg_next         = mode_reg;
    baud_reg_next         = baud_reg;
    rx_count_next         = rx_count;
    tx_hold_next          = tx_hold;
    tx_full_next          = tx_full;
    txen_latched_next     = txen_latched;
    overrun_flag_next     = overrun_flag;
    intr_flag_next        = intr_flag;
    irq_line_next         = irq_line;
    dsr_level_next        = dsr_level;
    cts_level_next        = cts_level;
    sent_dtr_next         = sent_dtr;
    sent_rts_next         = sent_rts;
    sent_count_next       = sent_count;
    peer_count_next       = peer_count;
    initial_sync_due_next = initial_sync_due;
    do_pop                = 1'b0;
    do_push               = 1'b0;
    rdata_next            = '0;
    tx_send_next          = 1'b0;
    tx_sync_next          = '0;
    tx_byte_next          = '0;
    tx_go                 = 1'b0;
    reply                 = 1'b0;
    count6                = '0;

    case (s1_cmd)
      CMD_READ: begin
        case (s1_offset)
          OFS_DATA: begin
            if (rx_count == '0) begin
              // empty fifo reads all ones and pops nothing
              rdata_next = READ_ONES;
            end else begin
              rdata_next    = fifo_word;
              do_pop        = 1'b1;
              rx_count_next = rx_count - CW'(pop_cnt);
            end
          end
          OFS_STATUS:  rdata_next = status_word;
          OFS_MODE:    rdata_next = 32'(mode_reg);
          OFS_CONTROL: rdata_next = 32'(control_reg);
          OFS_BAUD:    rdata_next = 32'(baud_reg);
          default:     rdata_next = READ_ONES;
        endcase
      end

      CMD_WRITE: begin
        case (s1_offset)
          OFS_DATA: begin
            // a write while full overwrites the holding byte
            tx_hold_next = s1_wdata[7:0];
            tx_full_next = 1'b1;
          end
          OFS_CONTROL: begin
            if (s1_wdata[CTL_RESET]) begin
              // soft reset also clears control, so ack and rx enable read as zero
              control_reg_next  = '0;
              mode_reg_next     = '0;
              baud_reg_next     = BAUD_RESET;
              rx_count_next     = '0;
              overrun_flag_next = 1'b0;
              intr_flag_next    = 1'b0;
              tx_hold_next      = '0;
              tx_full_next      = 1'b0;
            end else begin
              control_reg_next = s1_wdata[15:0];
              if (s1_wdata[CTL_ACK]) begin
                overrun_flag_next = 1'b0;
                intr_flag_next    = 1'b0;
                irq_line_next     = 1'b0;
              end
              if (!s1_wdata[CTL_RXEN]) begin
                rx_count_next     = '0;
                overrun_flag_next = 1'b0;
              end
            end
          end
          OFS_MODE: mode_reg_next = s1_wdata[15:0];
          OFS_BAUD: baud_reg_next = s1_wdata[15:0];
          default: ;
        endcase
      end

      CMD_TICK: begin
        if (!s1_link_up) begin
          cts_level_next = 1'b1;
          dsr_level_next = 1'b0;
          sent_dtr_next  = 1'b0;
          sent_rts_next  = 1'b0;
        end else begin
          reply                 = initial_sync_due;
          initial_sync_due_next = 1'b0;
          if (s1_rx_valid) begin
            if (s1_rx_sync[SYN_DATA]) begin
              reply = 1'b1;
              if (rx_count >= DEPTH_C) begin
                overrun_flag_next = 1'b1;
              end else begin
                do_push       = 1'b1;
                rx_count_next = rx_count + CW'(1);
              end
              if (control_reg[CTL_RXIE] && !intr_flag && rx_count_next >= CW'(rx_thr)) begin
                intr_flag_next = 1'b1;
                irq_line_next  = 1'b1;
              end
            end
            // dsr rising edge interrupt
            if (s1_rx_sync[SYN_DTR] && !dsr_level && control_reg[CTL_DSRIE]) begin
              intr_flag_next = 1'b1;
              irq_line_next  = 1'b1;
            end
            dsr_level_next  = s1_rx_sync[SYN_DTR];
            cts_level_next  = s1_rx_sync[SYN_RTS];
            peer_count_next = PEER_W'(s1_rx_sync[7:3]);
          end

          tx_go = (control_reg[CTL_TXEN] || txen_latched) && cts_level_next && tx_full
                  && (peer_count_next < DEPTH_P);
          txen_latched_next = control_reg[CTL_TXEN];

          // send a pair when anything the peer sees has changed, a byte is to go out or a reply is due
          if (control_reg[CTL_DTR] != sent_dtr || control_reg[CTL_RTS] != sent_rts
              || rx_count_next != sent_count || tx_go || reply) begin
            sent_dtr_next   = control_reg[CTL_DTR];
            sent_rts_next   = control_reg[CTL_RTS];
            sent_count_next = rx_count_next;
            count6          = 6'(rx_count_next);
            tx_send_next    = 1'b1;
            tx_sync_next    = {count6[4:0], control_reg[CTL_RTS], control_reg[CTL_DTR], tx_go};
            if (tx_go) begin
              peer_count_next = peer_count_next + PEER_W'(1);
              tx_byte_next    = tx_hold;
              tx_full_next    = 1'b0;
              if (control_reg[CTL_TXIE]) begin
                intr_flag_next = 1'b1;
                irq_line_next  = 1'b1;
              end
            end
          end
        end
      end

      default: ;
    endcase
  end

  // state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg      <= '0;
      mode_reg         <= '0;
      baud_reg         <= BAUD_RESET;
      rx_count         <= '0;
      tx_hold          <= '0;
      tx_full          <= 1'b0;
      txen_latched     <= 1'b0;
      overrun_flag     <= 1'b0;
      intr_flag        <= 1'b0;
      irq_line         <= 1'b0;
      dsr_level        <= 1'b0;
      cts_level        <= 1'b0;
      sent_dtr         <= 1'b0;
      sent_rts         <= 1'b0;
      sent_count       <= '0;
      peer_count       <= '0;
      initial_sync_due <= 1'b1;
    end else if (s1_advance) begin
      control_reg      <= control_reg_next;
      mode_reg         <= mode_reg_next;
      baud_reg         <= baud_reg_next;
      rx_count         <= rx_count_next;
      tx_hold          <= tx_hold_next;
      tx_full          <= tx_full_next;
      txen_latched     <= txen_latched_next;
      overrun_flag     <= overrun_flag_next;
      intr_flag        <= intr_flag_next;
      irq_line         <= irq_line_next;
      dsr_level        <= dsr_level_next;
      cts_level        <= cts_level_next;
      sent_dtr         <= sent_dtr_next;
      sent_rts         <= sent_rts_next;
      sent_count       <= sent_count_next;
      peer_count       <= peer_count_next;
      initial_sync_due <= initial_sync_due_next;
    end
  end

  // fifo bytes: shift down on a pop, write at the fill position on a push
  always_ff @(posedge clk) begin
    if (s1_advance && do_pop) begin
      rx_store <= shifted;
    end else if (s1_advance && do_push) begin
      rx_store[wr_idx] <= s1_rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rdata   <= rdata_next;
      tx_send <= tx_send_next;
      tx_sync <= tx_sync_next;
      tx_byte <= tx_byte_next;
      irq     <= irq_line_next;
    end
  end

endmodule

`default_nettype wire
